/* rtl/core/nhes_pkg.sv */
// ----------------------------------------------------------------------------
// nhes_pkg: shared types and constants
// Word layouts, register indexes and the divider request/response bundles of
// the neo-Hookean energy and stress block.
// ----------------------------------------------------------------------------
package nhes_pkg;

  localparam int DATA_W      = 32;
  localparam int MOD_W       = 31;
  localparam int LOG_BITS    = 24;
  localparam int NUM_W       = 56;  // c << FRAC_BITS at the largest fraction width
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BULK  = 2'd1;

  localparam logic [MOD_W-1:0] MOD_RESET = 31'd65536;

  // ln 2 in Q.30
  localparam logic signed [DATA_W:0] LN2_Q30 = 33'sd744261118;

  typedef struct packed {
    logic signed [DATA_W-1:0] grad_00;
    logic signed [DATA_W-1:0] grad_01;
    logic signed [DATA_W-1:0] grad_02;
    logic signed [DATA_W-1:0] grad_10;
    logic signed [DATA_W-1:0] grad_11;
    logic signed [DATA_W-1:0] grad_12;
    logic signed [DATA_W-1:0] grad_20;
    logic signed [DATA_W-1:0] grad_21;
    logic signed [DATA_W-1:0] grad_22;
  } grad_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] strain_energy;
    logic signed [DATA_W-1:0] stress_col0;
    logic signed [DATA_W-1:0] stress_col1;
    logic signed [DATA_W-1:0] stress_col2;
    logic signed [DATA_W-1:0] dmu_col0;
    logic signed [DATA_W-1:0] dmu_col1;
    logic signed [DATA_W-1:0] dmu_col2;
    logic signed [DATA_W-1:0] dlam_col0;
    logic signed [DATA_W-1:0] dlam_col1;
    logic signed [DATA_W-1:0] dlam_col2;
    logic                     invalid;
    logic                     last_row;
  } res_word_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic [MOD_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/core/nhes_if.sv */
// ----------------------------------------------------------------------------
// nhes_if: valid/ready channels
// Input channel carries one deformation gradient word, output channel one
// result row word.
// ----------------------------------------------------------------------------
interface nhes_in_if;
  logic                   valid;
  logic                   ready;
  nhes_pkg::grad_word_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface nhes_out_if;
  logic                   valid;
  logic                   ready;
  nhes_pkg::res_word_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/nhes_queue.sv */
// ----------------------------------------------------------------------------
// nhes_queue: input front end
// Accepts gradient words and holds them in a short queue so the engine can
// stall independently of the upstream side.
// ----------------------------------------------------------------------------
module nhes_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  nhes_in_if.sink              in_ch,
  output logic                 head_valid,
  output nhes_pkg::grad_word_t head_data,
  input  logic                 head_pop
);

  localparam int DEPTH = nhes_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nhes_pkg::grad_word_t q_mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]     count_r;
  logic                 push, pop;

  assign in_ch.ready = (count_r != CNT_W'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = head_pop && (count_r != '0);
  assign head_valid  = (count_r != '0);
  assign head_data   = q_mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= in_ch.data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

/* rtl/core/nhes_div.sv */
// ----------------------------------------------------------------------------
// nhes_div: rounded signed divider
// Radix-2 restoring divider, one quotient bit per cycle, rounding to nearest
// with halves away from zero and clamping to the signed 32-bit range.
// ----------------------------------------------------------------------------
module nhes_div (
  input  logic               clk,
  input  logic               rst_n,
  input  nhes_pkg::div_req_t req,
  output nhes_pkg::div_rsp_t rsp
);

  localparam int DW    = nhes_pkg::DATA_W;
  localparam int NW    = nhes_pkg::NUM_W;
  localparam int UW    = NW + 1;
  localparam int MW    = nhes_pkg::MOD_W;
  localparam int CNT_W = $clog2(DW);

  logic              busy_r, done_r, neg_r, sat_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DW-1:0]     rem_r, ulow_r, quo_r;
  logic [MW-1:0]     den_r;

  logic [NW-1:0]     mag;
  logic [UW-1:0]     u;
  logic [UW-DW-1:0]  hi;
  logic              ovf;
  logic [DW-1:0]     trial;
  logic              fits;

  // operand setup: magnitude plus half divisor, overflow when quotient >= 2^32
  always_comb begin
    mag   = req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
    u     = {1'b0, mag} + UW'(req.den >> 1);
    hi    = u[UW-1:DW];
    ovf   = (MW'(hi) >= req.den);
    trial = {rem_r[DW-2:0], ulow_r[DW-1]};
    fits  = (trial >= DW'(den_r));
  end

  // iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= DW'(hi);
        ulow_r <= u[DW-1:0];
        quo_r  <= '0;
        den_r  <= req.den;
        neg_r  <= req.num[NW-1];
        sat_r  <= ovf;
      end else if (busy_r) begin
        rem_r  <= fits ? trial - DW'(den_r) : trial;
        quo_r  <= {quo_r[DW-2:0], fits};
        ulow_r <= {ulow_r[DW-2:0], 1'b0};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // sign and clamp
  always_comb begin
    rsp.done = done_r;
    if (neg_r) begin
      if (sat_r || (quo_r > {1'b1, {(DW-1){1'b0}}})) rsp.quot = {1'b1, {(DW-1){1'b0}}};
      else                                            rsp.quot = -$signed(quo_r);
    end else begin
      if (sat_r || quo_r[DW-1]) rsp.quot = {1'b0, {(DW-1){1'b1}}};
      else                      rsp.quot = $signed(quo_r);
    end
  end

endmodule

/* rtl/core/nhes_engine.sv */
// ----------------------------------------------------------------------------
// nhes_engine: back end sequencer
// Works one gradient word at a time through a shared multiplier: invariant,
// cofactors, determinant, log, energy, then per element the inverse
// transpose and stresses; pushes one row word per row into an output register.
// ----------------------------------------------------------------------------
module nhes_engine #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     head_valid,
  input  nhes_pkg::grad_word_t     head_data,
  output logic                     head_pop,
  input  logic [nhes_pkg::MOD_W-1:0] shear_mu,
  input  logic [nhes_pkg::MOD_W-1:0] bulk_lam,
  output nhes_pkg::div_req_t       div_req,
  input  nhes_pkg::div_rsp_t       div_rsp,
  nhes_out_if.source               out_ch
);

  localparam int DW       = nhes_pkg::DATA_W;
  localparam int OP_W     = DW + 1;
  localparam int P_W      = 2 * OP_W;
  localparam int ACC_W    = P_W + 2;
  localparam int LB       = nhes_pkg::LOG_BITS;
  localparam int LN_SHIFT = 30 + LB - FRAC_BITS;
  localparam int NW       = nhes_pkg::NUM_W;
  localparam logic signed [ACC_W-1:0] THREE_Q = ACC_W'(64'd3 << FRAC_BITS);

  // operation phases: operand fetch, multiply, use product
  localparam logic [1:0] PH_PREP = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_USE  = 2'd2;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_LOAD  = 12'b0000_0000_0010,
    ST_SQ    = 12'b0000_0000_0100,
    ST_COF   = 12'b0000_0000_1000,
    ST_DET   = 12'b0000_0001_0000,
    ST_NORM  = 12'b0000_0010_0000,
    ST_LOGSQ = 12'b0000_0100_0000,
    ST_LN    = 12'b0000_1000_0000,
    ST_EN    = 12'b0001_0000_0000,
    ST_DIV   = 12'b0010_0000_0000,
    ST_ELEM  = 12'b0100_0000_0000,
    ST_PUSH  = 12'b1000_0000_0000
  } eng_state_t;

  function automatic logic [1:0] inc3(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  function automatic logic [3:0] e_addr(input logic [1:0] r, input logic [1:0] c);
    return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
  endfunction

  // round half up, then floor shift
  function automatic logic signed [ACC_W-1:0] rnd(input logic signed [P_W-1:0] x,
                                                  input int s);
    logic signed [ACC_W-1:0] half;
    half = '0;
    half[s-1] = 1'b1;
    return (ACC_W'(x) + half) >>> s;
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [ACC_W-1:0] x);
    if ((&x[ACC_W-1:DW-1]) || !(|x[ACC_W-1:DW-1])) return x[DW-1:0];
    else if (x[ACC_W-1])                         return {1'b1, {(DW-1){1'b0}}};
    else                                         return {1'b0, {(DW-1){1'b1}}};
  endfunction

  function automatic logic signed [DW-1:0] grad_sel(input nhes_pkg::grad_word_t w,
                                                    input logic [3:0] idx);
    case (idx)
      4'd0:    return w.grad_00;
      4'd1:    return w.grad_01;
      4'd2:    return w.grad_02;
      4'd3:    return w.grad_10;
      4'd4:    return w.grad_11;
      4'd5:    return w.grad_12;
      4'd6:    return w.grad_20;
      4'd7:    return w.grad_21;
      4'd8:    return w.grad_22;
      default: return '0;
    endcase
  endfunction

  eng_state_t state_r;
  logic [1:0] ph_r, row_r, col_r, sub_r;
  logic [4:0] p_r, lg_cnt_r;
  logic [DW-1:0] m_r;
  logic [LB-1:0] bits_r;
  logic bad_r;

  logic signed [DW-1:0]    f_mem [9];
  logic signed [DW-1:0]    c_mem [9];
  logic signed [DW-1:0]    fa_q, fb_q, c_q;
  logic signed [P_W-1:0]   prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [DW-1:0]    i1_r, j_r, lnj_r, t_r, sq_r, energy_r, g_r, dm_r, dl_r;
  logic signed [DW-1:0]    row_pm [3];
  logic signed [DW-1:0]    row_dm [3];
  logic signed [DW-1:0]    row_dl [3];
  logic                    out_valid_r;
  nhes_pkg::res_word_t     out_data_r;

  logic [1:0] ia, ib, ka, kb;
  logic [3:0] eidx, addr_a, addr_b;
  logic       last, rd_en, c_we;
  logic signed [DW-1:0]    f_wdata, cof_val, jsum, l_val;
  logic signed [OP_W-1:0]  opa, opb;
  logic signed [ACC_W-1:0] rq, rq1, rln;
  logic [DW-1:0]           mm;
  logic                    out_free;

  // address, operand and rounding decode
  always_comb begin
    ia      = inc3(row_r);
    ib      = inc3(ia);
    ka      = inc3(col_r);
    kb      = inc3(ka);
    eidx    = e_addr(row_r, col_r);
    last    = (row_r == 2'd2) && (col_r == 2'd2);
    f_wdata = grad_sel(head_data, eidx);
    rd_en   = (ph_r == PH_PREP) && (state_r inside {ST_SQ, ST_COF, ST_DET, ST_DIV});
    addr_a  = eidx;
    addr_b  = eidx;
    if (state_r == ST_COF) begin
      addr_a = (sub_r == 2'd0) ? e_addr(ia, ka) : e_addr(ia, kb);
      addr_b = (sub_r == 2'd0) ? e_addr(ib, kb) : e_addr(ib, ka);
    end
    rq      = rnd(prod_r, FRAC_BITS);
    rq1     = rnd(prod_r, FRAC_BITS + 1);
    rln     = rnd(prod_r, LN_SHIFT);
    cof_val = sat32(acc_r - rq);
    jsum    = sat32(acc_r + rq);
    c_we    = (state_r == ST_COF) && (ph_r == PH_USE) && (sub_r == 2'd1);
    mm      = prod_r[DW+29:30];
    l_val   = {8'(signed'({3'b000, p_r}) - 8'(FRAC_BITS)), bits_r};
    out_free = !out_valid_r || out_ch.ready;

    opa = {fa_q[DW-1], fa_q};
    opb = {fa_q[DW-1], fa_q};
    case (state_r)
      ST_COF:   opb = {fb_q[DW-1], fb_q};
      ST_DET:   opb = {c_q[DW-1], c_q};
      ST_LOGSQ: begin
        opa = {1'b0, m_r};
        opb = {1'b0, m_r};
      end
      ST_LN: begin
        opa = {l_val[DW-1], l_val};
        opb = nhes_pkg::LN2_Q30;
      end
      ST_EN: begin
        case (sub_r)
          2'd0:    begin opa = {lnj_r[DW-1], lnj_r}; opb = {lnj_r[DW-1], lnj_r}; end
          2'd1:    begin opa = {2'b00, shear_mu}; opb = {t_r[DW-1], t_r}; end
          default: begin opa = {2'b00, bulk_lam}; opb = {sq_r[DW-1], sq_r}; end
        endcase
      end
      ST_ELEM: begin
        case (sub_r)
          2'd0:    begin opa = {lnj_r[DW-1], lnj_r}; opb = {g_r[DW-1], g_r}; end
          2'd1:    begin opa = {2'b00, shear_mu}; opb = {dm_r[DW-1], dm_r}; end
          default: begin opa = {2'b00, bulk_lam}; opb = {dl_r[DW-1], dl_r}; end
        endcase
      end
      default: ;
    endcase
  end

  assign head_pop     = (state_r == ST_LOAD) && last;
  assign div_req.start = (state_r == ST_DIV) && (ph_r == PH_MUL);
  assign div_req.num   = NW'(c_q) <<< FRAC_BITS;
  assign div_req.den   = j_r[nhes_pkg::MOD_W-1:0];
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_data_r;

  // gradient and cofactor memories, registered reads
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) f_mem[eidx] <= f_wdata;
    if (rd_en) begin
      fa_q <= f_mem[addr_a];
      fb_q <= f_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) c_mem[eidx] <= cof_val;
    if (rd_en) c_q <= c_mem[eidx];
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_PREP;
      row_r       <= '0;
      col_r       <= '0;
      sub_r       <= '0;
      lg_cnt_r    <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (head_valid) begin
            state_r <= ST_LOAD;
            row_r   <= '0;
            col_r   <= '0;
          end
        end

        // copy the head word into the gradient memory
        ST_LOAD: begin
          if (last) begin
            state_r <= ST_SQ;
            row_r   <= '0;
            col_r   <= '0;
            ph_r    <= PH_PREP;
            acc_r   <= '0;
          end else begin
            col_r <= inc3(col_r);
            if (col_r == 2'd2) row_r <= row_r + 2'd1;
          end
        end

        // first invariant: sum of rounded squares
        ST_SQ: begin
          if (ph_r == PH_USE) begin
            ph_r  <= PH_PREP;
            acc_r <= acc_r + rq;
            if (last) begin
              i1_r    <= sat32(acc_r + rq);
              acc_r   <= '0;
              state_r <= ST_COF;
              row_r   <= '0;
              col_r   <= '0;
              sub_r   <= '0;
            end else begin
              col_r <= inc3(col_r);
              if (col_r == 2'd2) row_r <= row_r + 2'd1;
            end
          end else ph_r <= ph_r + 2'd1;
        end

        // cofactors, two products each
        ST_COF: begin
          if (ph_r == PH_USE) begin
            ph_r <= PH_PREP;
            if (sub_r == 2'd0) begin
              acc_r <= rq;
              sub_r <= 2'd1;
            end else begin
              acc_r <= '0;
              sub_r <= 2'd0;
              if (last) begin
                state_r <= ST_DET;
                row_r   <= '0;
                col_r   <= '0;
              end else begin
                col_r <= inc3(col_r);
                if (col_r == 2'd2) row_r <= row_r + 2'd1;
              end
            end
          end else ph_r <= ph_r + 2'd1;
        end

        // determinant along row zero
        ST_DET: begin
          if (ph_r == PH_USE) begin
            ph_r  <= PH_PREP;
            acc_r <= acc_r + rq;
            if (col_r == 2'd2) begin
              j_r   <= jsum;
              acc_r <= '0;
              row_r <= '0;
              col_r <= '0;
              if (jsum[DW-1] || (jsum == '0)) begin
                bad_r   <= 1'b1;
                state_r <= ST_PUSH;
              end else begin
                bad_r   <= 1'b0;
                m_r     <= {1'b0, jsum[DW-2:0]};
                p_r     <= 5'd30;
                state_r <= ST_NORM;
              end
            end else col_r <= col_r + 2'd1;
          end else ph_r <= ph_r + 2'd1;
        end

        // normalize J to Q1.30, one bit per cycle
        ST_NORM: begin
          if ((p_r != '0) && !m_r[30]) begin
            m_r <= {m_r[DW-2:0], 1'b0};
            p_r <= p_r - 5'd1;
          end else begin
            state_r  <= ST_LOGSQ;
            lg_cnt_r <= '0;
            bits_r   <= '0;
            ph_r     <= PH_PREP;
          end
        end

        // log2 fraction by repeated squaring
        ST_LOGSQ: begin
          if (ph_r == PH_USE) begin
            ph_r <= PH_PREP;
            if (mm[DW-1]) begin
              m_r    <= mm >> 1;
              bits_r <= {bits_r[LB-2:0], 1'b1};
            end else begin
              m_r    <= mm;
              bits_r <= {bits_r[LB-2:0], 1'b0};
            end
            if (lg_cnt_r == 5'(LB - 1)) state_r <= ST_LN;
            else                        lg_cnt_r <= lg_cnt_r + 5'd1;
          end else ph_r <= ph_r + 2'd1;
        end

        // natural log from log2
        ST_LN: begin
          if (ph_r == PH_USE) begin
            ph_r    <= PH_PREP;
            lnj_r   <= sat32(rln);
            state_r <= ST_EN;
            sub_r   <= '0;
          end else ph_r <= ph_r + 2'd1;
        end

        // energy: lnJ^2, mu*t, lam*lnJ^2
        ST_EN: begin
          if (ph_r == PH_USE) begin
            ph_r <= PH_PREP;
            case (sub_r)
              2'd0: begin
                sq_r  <= sat32(rq);
                sub_r <= 2'd1;
              end
              2'd1: begin
                acc_r <= rq1;
                sub_r <= 2'd2;
              end
              default: begin
                energy_r <= sat32(acc_r + rq1);
                acc_r    <= '0;
                sub_r    <= '0;
                state_r  <= ST_DIV;
                row_r    <= '0;
                col_r    <= '0;
              end
            endcase
          end else begin
            if ((ph_r == PH_PREP) && (sub_r == 2'd0))
              t_r <= sat32(ACC_W'(i1_r) - (ACC_W'(lnj_r) <<< 1) - THREE_Q);
            ph_r <= ph_r + 2'd1;
          end
        end

        // inverse transpose element: C * 2^q / J
        ST_DIV: begin
          if (ph_r == PH_USE) begin
            if (div_rsp.done) begin
              g_r     <= div_rsp.quot;
              state_r <= ST_ELEM;
              sub_r   <= '0;
              ph_r    <= PH_PREP;
            end
          end else ph_r <= ph_r + 2'd1;
        end

        // element derivatives and stress
        ST_ELEM: begin
          if (ph_r == PH_USE) begin
            ph_r <= PH_PREP;
            case (sub_r)
              2'd0: begin
                dl_r          <= sat32(rq);
                row_dl[col_r] <= sat32(rq);
                row_dm[col_r] <= dm_r;
                sub_r         <= 2'd1;
              end
              2'd1: begin
                acc_r <= rq;
                sub_r <= 2'd2;
              end
              default: begin
                row_pm[col_r] <= sat32(acc_r + rq);
                acc_r         <= '0;
                sub_r         <= '0;
                if (col_r == 2'd2) state_r <= ST_PUSH;
                else begin
                  col_r   <= col_r + 2'd1;
                  state_r <= ST_DIV;
                end
              end
            endcase
          end else begin
            if ((ph_r == PH_PREP) && (sub_r == 2'd0))
              dm_r <= sat32(ACC_W'(fa_q) - ACC_W'(g_r));
            ph_r <= ph_r + 2'd1;
          end
        end

        // hand one row word to the output register
        ST_PUSH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r.strain_energy <= bad_r ? '0 : energy_r;
            out_data_r.stress_col0   <= bad_r ? '0 : row_pm[0];
            out_data_r.stress_col1   <= bad_r ? '0 : row_pm[1];
            out_data_r.stress_col2   <= bad_r ? '0 : row_pm[2];
            out_data_r.dmu_col0      <= bad_r ? '0 : row_dm[0];
            out_data_r.dmu_col1      <= bad_r ? '0 : row_dm[1];
            out_data_r.dmu_col2      <= bad_r ? '0 : row_dm[2];
            out_data_r.dlam_col0     <= bad_r ? '0 : row_dl[0];
            out_data_r.dlam_col1     <= bad_r ? '0 : row_dl[1];
            out_data_r.dlam_col2     <= bad_r ? '0 : row_dl[2];
            out_data_r.invalid       <= bad_r;
            out_data_r.last_row      <= (row_r == 2'd2);
            col_r <= '0;
            ph_r  <= PH_PREP;
            if (row_r == 2'd2) state_r <= ST_IDLE;
            else begin
              row_r   <= row_r + 2'd1;
              state_r <= bad_r ? ST_PUSH : ST_DIV;
            end
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/neohookean_energy_stress.sv */
// ----------------------------------------------------------------------------
// neohookean_energy_stress: neo-Hookean energy and PK1 stress, 3x3, fixed point
// Each word runs through the shared 33x33 multiplier and the inverse entry
//   divider; a word whose determinant is not positive skips to zeroed rows.
//   A new word enters the engine only after the last row word of the previous
//   one; meanwhile the input queue holds up to two more.
// Reset (rst_n, synchronous): queue empty, engine idle, mu = lambda = 1.0.
// ----------------------------------------------------------------------------
module neohookean_energy_stress #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  nhes_in_if.sink                             in_ch,
  nhes_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [nhes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nhes_pkg::MOD_W-1:0]          cfg_wdata
);

  logic [nhes_pkg::MOD_W-1:0] mu_r, lam_r;
  logic                       head_valid, head_pop;
  nhes_pkg::grad_word_t       head_data;
  nhes_pkg::div_req_t         div_req;
  nhes_pkg::div_rsp_t         div_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r  <= nhes_pkg::MOD_RESET;
      lam_r <= nhes_pkg::MOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        nhes_pkg::REG_SHEAR: mu_r  <= cfg_wdata;
        nhes_pkg::REG_BULK:  lam_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  nhes_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .head_valid (head_valid),
    .head_data  (head_data),
    .head_pop   (head_pop)
  );

  nhes_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  nhes_engine #(
    .FRAC_BITS (FRAC_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .head_pop   (head_pop),
    .shear_mu   (mu_r),
    .bulk_lam   (lam_r),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_ch     (out_ch)
  );

endmodule
